@@ rtl/core/mtoh_pkg.sv @@
// ----------------------------------------------------------------------------
// mtoh_pkg
// Shared widths, constants, payload types and the 2^(2^-k) factor table of
// the mel to hertz converter.
// ----------------------------------------------------------------------------
package mtoh_pkg;

    localparam int unsigned MEL_W = 20;
    localparam int unsigned HZ_W  = 23;

    localparam int unsigned DEF_MEL_FRAC_BITS = 8;
    localparam int unsigned DEF_HZ_FRAC_BITS  = 8;

    // log2(10) in Q2.30, split as LOG2_TEN = SCALE_Q * 2595 + SCALE_R
    localparam longint unsigned LOG2_TEN_Q30 = 64'd3566893132;
    localparam longint unsigned MEL_DIVISOR  = 64'd2595;
    localparam longint unsigned SCALE_Q      = LOG2_TEN_Q30 / MEL_DIVISOR;
    localparam longint unsigned SCALE_R      = LOG2_TEN_Q30 % MEL_DIVISOR;

    // reciprocal of 2595 for the remainder division
    localparam int unsigned     RECIP_SHIFT = 42;
    localparam longint unsigned RECIP_M     = (64'd1 << RECIP_SHIFT) / MEL_DIVISOR;

    localparam int unsigned MQ_W  = 41;   // mel * SCALE_Q, also the full quotient
    localparam int unsigned N_W   = 30;   // mel * SCALE_R
    localparam int unsigned Q0_W  = 19;   // (mel * SCALE_R) / 2595
    localparam int unsigned RP_W  = 61;   // N * RECIP_M

    localparam int unsigned FRAC_STEPS = 16;
    localparam int unsigned EXP_W      = 4;
    localparam int unsigned P_W        = 32;
    localparam int unsigned POW_W      = 47;
    localparam int unsigned HZP_W      = 57;

    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned HALF_Q30 = 64'd1 << 29;
    localparam longint unsigned HZ_SCALE = 64'd700;
    localparam longint unsigned HZ_MAX   = (64'd1 << HZ_W) - 64'd1;

    // 2^(2^-k) in Q2.30, k = 1..16
    localparam logic [30:0] POW_FACTOR [FRAC_STEPS] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280437,
        31'd1097253710, 31'd1085434106, 31'd1079572136, 31'd1076653033,
        31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544,
        31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
    };

    typedef struct packed {
        logic [MEL_W-1:0] mel_value;
        logic             is_last;
    } t_mel_beat;

    typedef struct packed {
        logic                  sat;
        logic [EXP_W-1:0]      e;
        logic [FRAC_STEPS-1:0] f;
        logic                  last;
    } t_xsplit;

    typedef struct packed {
        logic             sat;
        logic [EXP_W-1:0] e;
        logic [P_W-1:0]   p;
        logic             last;
    } t_pow;

    typedef struct packed {
        logic [HZ_W-1:0] hz_value;
        logic            end_of_array;
    } t_hz_beat;

endpackage

@@ rtl/core/mtoh_if.sv @@
// ----------------------------------------------------------------------------
// mtoh_if
// Valid/ready stream interfaces for the mel input and the hertz output.
// ----------------------------------------------------------------------------
interface mtoh_mel_if;
    logic                      valid;
    logic                      ready;
    logic [mtoh_pkg::MEL_W-1:0] mel_value;
    logic                      is_last;

    modport source (output valid, output mel_value, output is_last, input ready);
    modport sink   (input valid, input mel_value, input is_last, output ready);
endinterface

interface mtoh_hz_if;
    logic                     valid;
    logic                     ready;
    logic [mtoh_pkg::HZ_W-1:0] hz_value;
    logic                     end_of_array;

    modport source (output valid, output hz_value, output end_of_array, input ready);
    modport sink   (input valid, input hz_value, input end_of_array, output ready);
endinterface

@@ rtl/core/mel_to_hz_converter_core.sv @@
// ----------------------------------------------------------------------------
// mel_to_hz_converter_core
// Mel (Q12.8) to hertz (Q15.8), hz = 700 * (10^(mel/2595) - 1), rounded.
//
//   port    dir   beat fields                 notes
//   i_mel   in    mel_value[19:0], is_last    valid/ready, sink
//   o_hz    out   hz_value[22:0], end_of_array valid/ready, source
//
// one beat per cycle sustained while o_hz does not stall; the pipe is
// 4 scaling stages, 16 fractional-power multiply stages, 3 output stages
// and 1 output register; the 16 multiply stages set the depth
// reset clears all valid bits and the output buffer, payload is not reset
// output register plus one skid entry; i_mel.ready comes from a register, so
// a stall on o_hz freezes the pipe in the cycle after, with nothing lost
// ----------------------------------------------------------------------------
module mel_to_hz_converter_core #(
    parameter int unsigned MEL_FRAC_BITS = mtoh_pkg::DEF_MEL_FRAC_BITS,
    parameter int unsigned HZ_FRAC_BITS  = mtoh_pkg::DEF_HZ_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtoh_mel_if.sink   i_mel,
    mtoh_hz_if.source  o_hz
);

    logic                en;
    mtoh_pkg::t_mel_beat in_beat;

    logic                sc_valid;
    mtoh_pkg::t_xsplit   sc_data;
    logic                ex_valid;
    mtoh_pkg::t_pow      ex_data;
    logic                pv;
    mtoh_pkg::t_hz_beat  pd;

    logic                r_out_valid;
    mtoh_pkg::t_hz_beat  r_out_data;
    logic                r_hold_valid;
    mtoh_pkg::t_hz_beat  r_hold_data;

    logic                n_out_valid;
    logic                n_hold_valid;
    logic                out_free;
    logic                push;

    // the pipe moves whenever the skid entry is empty
    assign en          = !r_hold_valid;
    assign i_mel.ready = en;

    assign in_beat.mel_value = i_mel.mel_value;
    assign in_beat.is_last   = i_mel.is_last;

    mtoh_scale #(
        .MEL_FRAC_BITS (MEL_FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_mel.valid),
        .i_data  (in_beat),
        .o_valid (sc_valid),
        .o_data  (sc_data)
    );

    mtoh_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sc_valid),
        .i_data  (sc_data),
        .o_valid (ex_valid),
        .o_data  (ex_data)
    );

    mtoh_hz #(
        .HZ_FRAC_BITS (HZ_FRAC_BITS)
    ) u_hz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ex_valid),
        .i_data  (ex_data),
        .o_valid (pv),
        .o_data  (pd)
    );

    assign out_free = !r_out_valid || o_hz.ready;
    assign push     = en && pv;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_hold_valid = r_hold_valid;
        if (r_hold_valid) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_hold_valid = 1'b0;
            end
        end else if (push) begin
            if (out_free) begin
                n_out_valid = 1'b1;
            end else begin
                n_hold_valid = 1'b1;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hold_valid) begin
            if (out_free) begin
                r_out_data <= r_hold_data;
            end
        end else if (push) begin
            if (out_free) begin
                r_out_data <= pd;
            end else begin
                r_hold_data <= pd;
            end
        end
    end

    assign o_hz.valid        = r_out_valid;
    assign o_hz.hz_value     = r_out_data.hz_value;
    assign o_hz.end_of_array = r_out_data.end_of_array;

    // skid entry is only used behind a full output register
    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("skid entry filled while output register empty");

    // skid entry fills only after a stalled output beat
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hold_valid) |-> $past(r_out_valid && !o_hz.ready))
        else $error("skid entry filled without a stall");

endmodule

@@ rtl/core/mtoh_scale.sv @@
// ----------------------------------------------------------------------------
// mtoh_scale
// Four stages: x = floor(mel * log2(10) / (2595 << MEL_FRAC_BITS)) in Q.30,
// split into saturation flag, integer exponent and 16 fraction bits.
// ----------------------------------------------------------------------------
module mtoh_scale #(
    parameter int unsigned MEL_FRAC_BITS = mtoh_pkg::DEF_MEL_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  mtoh_pkg::t_mel_beat i_data,
    output logic                o_valid,
    output mtoh_pkg::t_xsplit   o_data
);

    // stage 1: split product by the quotient and remainder of log2(10) / 2595
    logic                          r_s1_valid;
    logic [mtoh_pkg::MQ_W-1:0]     r_s1_mq;
    logic [mtoh_pkg::N_W-1:0]      r_s1_n;
    logic                          r_s1_last;

    // stage 2: reciprocal estimate of n / 2595
    logic                          r_s2_valid;
    logic [mtoh_pkg::MQ_W-1:0]     r_s2_mq;
    logic [mtoh_pkg::N_W-1:0]      r_s2_n;
    logic [mtoh_pkg::Q0_W-1:0]     r_s2_q0;
    logic                          r_s2_last;

    // stage 3: corrected quotient
    logic                          r_s3_valid;
    logic [mtoh_pkg::MQ_W-1:0]     r_s3_mq;
    logic [mtoh_pkg::Q0_W-1:0]     r_s3_q;
    logic                          r_s3_last;

    // stage 4: split of x
    logic                          r_s4_valid;
    mtoh_pkg::t_xsplit             r_s4_data;

    logic [mtoh_pkg::RP_W-1:0]     n_rp;
    logic [mtoh_pkg::N_W-1:0]      n_rem;
    logic [mtoh_pkg::Q0_W-1:0]     n_q;
    logic [mtoh_pkg::MQ_W-1:0]     n_sum;
    logic [mtoh_pkg::MQ_W-1:0]     n_x;
    mtoh_pkg::t_xsplit             n_split;

    always_comb begin
        n_rp  = mtoh_pkg::RP_W'(r_s1_n) * mtoh_pkg::RP_W'(mtoh_pkg::RECIP_M);
        n_rem = r_s2_n - mtoh_pkg::N_W'(r_s2_q0) * mtoh_pkg::N_W'(mtoh_pkg::MEL_DIVISOR);
        n_q   = (n_rem >= mtoh_pkg::N_W'(mtoh_pkg::MEL_DIVISOR)) ? r_s2_q0 + 1'b1 : r_s2_q0;
        n_sum = r_s3_mq + mtoh_pkg::MQ_W'(r_s3_q);
        n_x   = n_sum >> MEL_FRAC_BITS;
        n_split.sat  = |n_x[mtoh_pkg::MQ_W-1:30+mtoh_pkg::EXP_W];
        n_split.e    = n_x[30 +: mtoh_pkg::EXP_W];
        n_split.f    = n_x[30-mtoh_pkg::FRAC_STEPS +: mtoh_pkg::FRAC_STEPS];
        n_split.last = r_s3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mq   <= mtoh_pkg::MQ_W'(i_data.mel_value) * mtoh_pkg::MQ_W'(mtoh_pkg::SCALE_Q);
            r_s1_n    <= mtoh_pkg::N_W'(i_data.mel_value) * mtoh_pkg::N_W'(mtoh_pkg::SCALE_R);
            r_s1_last <= i_data.is_last;
            r_s2_mq   <= r_s1_mq;
            r_s2_n    <= r_s1_n;
            r_s2_q0   <= n_rp[mtoh_pkg::RECIP_SHIFT +: mtoh_pkg::Q0_W];
            r_s2_last <= r_s1_last;
            r_s3_mq   <= r_s2_mq;
            r_s3_q    <= n_q;
            r_s3_last <= r_s2_last;
            r_s4_data <= n_split;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_data  = r_s4_data;

    // the reciprocal estimate is never more than one below the true quotient
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (n_rem < mtoh_pkg::N_W'(2 * mtoh_pkg::MEL_DIVISOR)))
        else $error("quotient correction out of range");

endmodule

@@ rtl/core/mtoh_exp2.sv @@
// ----------------------------------------------------------------------------
// mtoh_exp2
// Sixteen multiply stages building 2^f in Q2.30, one table factor per
// fraction bit, most significant bit first, each product rounded.
// ----------------------------------------------------------------------------
module mtoh_exp2 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  mtoh_pkg::t_xsplit i_data,
    output logic              o_valid,
    output mtoh_pkg::t_pow    o_data
);

    localparam int unsigned STEPS = mtoh_pkg::FRAC_STEPS;
    localparam int unsigned PR_W  = 63;

    logic [STEPS:0]              v;
    mtoh_pkg::t_xsplit           side [0:STEPS];
    logic [mtoh_pkg::P_W-1:0]    p    [0:STEPS];

    assign v[0]    = i_valid;
    assign side[0] = i_data;
    assign p[0]    = mtoh_pkg::P_W'(mtoh_pkg::ONE_Q30);

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                     r_valid;
        mtoh_pkg::t_xsplit        r_side;
        logic [mtoh_pkg::P_W-1:0] r_p;
        logic [PR_W-1:0]          n_prod;
        logic [mtoh_pkg::P_W-1:0] n_p;

        always_comb begin
            n_prod = PR_W'(p[k]) * PR_W'(mtoh_pkg::POW_FACTOR[k])
                   + PR_W'(mtoh_pkg::HALF_Q30);
            n_p    = side[k].f[STEPS-1-k] ? n_prod[30 +: mtoh_pkg::P_W] : p[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= side[k];
                r_p    <= n_p;
            end
        end

        assign v[k+1]    = r_valid;
        assign side[k+1] = r_side;
        assign p[k+1]    = r_p;
    end

    assign o_valid     = v[STEPS];
    assign o_data.sat  = side[STEPS].sat;
    assign o_data.e    = side[STEPS].e;
    assign o_data.p    = p[STEPS];
    assign o_data.last = side[STEPS].last;

    // 2^f for f in [0, 1) stays in [1, 2)
    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[STEPS] |-> (p[STEPS][mtoh_pkg::P_W-1:30] == 2'b01))
        else $error("fractional power out of range");

endmodule

@@ rtl/core/mtoh_hz.sv @@
// ----------------------------------------------------------------------------
// mtoh_hz
// Three stages: shift by the exponent and subtract one, scale by 700 with
// rounding, saturate to the output width.
// ----------------------------------------------------------------------------
module mtoh_hz #(
    parameter int unsigned HZ_FRAC_BITS = mtoh_pkg::DEF_HZ_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mtoh_pkg::t_pow     i_data,
    output logic               o_valid,
    output mtoh_pkg::t_hz_beat o_data
);

    localparam int unsigned RND_SHIFT = 30 - HZ_FRAC_BITS;
    localparam logic [mtoh_pkg::HZP_W-1:0] RND = mtoh_pkg::HZP_W'(1) << (RND_SHIFT - 1);

    logic                          r_h1_valid;
    logic [mtoh_pkg::POW_W-1:0]    r_h1_diff;
    logic                          r_h1_sat;
    logic                          r_h1_last;

    logic                          r_h2_valid;
    logic [mtoh_pkg::HZP_W-1:0]    r_h2_hz;
    logic                          r_h2_sat;
    logic                          r_h2_last;

    logic                          r_h3_valid;
    mtoh_pkg::t_hz_beat            r_h3_data;

    logic [mtoh_pkg::POW_W-1:0]    n_pow;
    logic [mtoh_pkg::HZP_W-1:0]    n_prod;
    mtoh_pkg::t_hz_beat            n_out;

    always_comb begin
        n_pow  = mtoh_pkg::POW_W'(i_data.p) << i_data.e;
        n_prod = mtoh_pkg::HZP_W'(r_h1_diff) * mtoh_pkg::HZP_W'(mtoh_pkg::HZ_SCALE) + RND;
        if (r_h2_sat || (r_h2_hz > mtoh_pkg::HZP_W'(mtoh_pkg::HZ_MAX))) begin
            n_out.hz_value = mtoh_pkg::HZ_W'(mtoh_pkg::HZ_MAX);
        end else begin
            n_out.hz_value = r_h2_hz[mtoh_pkg::HZ_W-1:0];
        end
        n_out.end_of_array = r_h2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_valid <= 1'b0;
            r_h2_valid <= 1'b0;
            r_h3_valid <= 1'b0;
        end else if (i_en) begin
            r_h1_valid <= i_valid;
            r_h2_valid <= r_h1_valid;
            r_h3_valid <= r_h2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1_diff <= n_pow - mtoh_pkg::POW_W'(mtoh_pkg::ONE_Q30);
            r_h1_sat  <= i_data.sat;
            r_h1_last <= i_data.last;
            r_h2_hz   <= n_prod >> RND_SHIFT;
            r_h2_sat  <= r_h1_sat;
            r_h2_last <= r_h1_last;
            r_h3_data <= n_out;
        end
    end

    assign o_valid = r_h3_valid;
    assign o_data  = r_h3_data;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mel_to_hz_converter_core: mel beats go in with
// random gaps and the hertz beats coming out are matched in order against a
// fixed-point model of 700 * (10^(mel/2595) - 1). The run covers directed
// corners, random traffic under three idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MEL_FB     = 8;
    localparam int unsigned HZ_FB      = 8;
    localparam longint unsigned L2T_Q30 = 64'd3566893132;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned HZ_TOP  = (64'd1 << mtoh_pkg::HZ_W) - 64'd1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 200;

    // 2^(2^-k) in Q2.30, k = 1..16
    localparam longint unsigned ROOT2_STEP [16] = '{
        64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280437,
        64'd1097253710, 64'd1085434106, 64'd1079572136, 64'd1076653033,
        64'd1075196443, 64'd1074468887, 64'd1074105294, 64'd1073923544,
        64'd1073832680, 64'd1073787251, 64'd1073764537, 64'd1073753181
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtoh_mel_if mel_bus ();
    mtoh_hz_if  hz_bus ();

    mel_to_hz_converter_core #(
        .MEL_FRAC_BITS(MEL_FB),
        .HZ_FRAC_BITS (HZ_FB)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mel  (mel_bus.sink),
        .o_hz   (hz_bus.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mtoh_pkg::t_hz_beat hz_pending[$];
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_ticket   = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;

    // hz = 700 * (2^x - 1), x = mel * log2(10) / 2595, rounded half up
    function automatic logic [mtoh_pkg::HZ_W-1:0] hz_of_mel(
        input logic [mtoh_pkg::MEL_W-1:0] mel);
        longint unsigned expo_q30;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned prod;
        longint unsigned hz;
        expo_q30 = (64'(mel) * L2T_Q30) / (64'd2595 << MEL_FB);
        whole    = expo_q30 >> 30;
        frac     = (expo_q30 & (Q30_ONE - 64'd1)) >> 14;
        if (whole >= 64'd16)
            return HZ_TOP[mtoh_pkg::HZ_W-1:0];
        prod = Q30_ONE;
        for (int k = 0; k < 16; k++) begin
            if (frac[15-k])
                prod = (prod * ROOT2_STEP[k] + (64'd1 << 29)) >> 30;
        end
        hz = (64'd700 * ((prod << whole) - Q30_ONE) + (64'd1 << (29 - HZ_FB)))
             >> (30 - HZ_FB);
        if (hz > HZ_TOP)
            hz = HZ_TOP;
        return hz[mtoh_pkg::HZ_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    task automatic send_mel(input logic [mtoh_pkg::MEL_W-1:0] mel, input logic last);
        mtoh_pkg::t_hz_beat want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            mel_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        mel_bus.valid     <= 1'b1;
        mel_bus.mel_value <= mel;
        mel_bus.is_last   <= last;
        @(posedge i_clk);
        while (!mel_bus.ready)
            @(posedge i_clk);
        want.hz_value     = hz_of_mel(mel);
        want.end_of_array = last;
        hz_pending.push_back(want);
    endtask

    // output side: random stall, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen     <= hold_ticket;
            hold_left     <= HOLD_CYCLES;
            hz_bus.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            hz_bus.ready  <= 1'b0;
        end else begin
            hz_bus.ready  <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        mtoh_pkg::t_hz_beat want;
        if (i_rst_n && hz_bus.valid && hz_bus.ready) begin
            if (hz_pending.size() == 0) begin
                report_mismatch("unexpected beat", hz_bus.hz_value, 0);
            end else begin
                want = hz_pending.pop_front();
                if (hz_bus.hz_value !== want.hz_value)
                    report_mismatch("hz_value", hz_bus.hz_value, want.hz_value);
                if (hz_bus.end_of_array !== want.end_of_array)
                    report_mismatch("end_of_array", hz_bus.end_of_array,
                                    want.end_of_array);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic test_corners();
        logic [mtoh_pkg::MEL_W-1:0] corner [] = '{
            20'h00000, 20'hFFFFF, 20'h00001, 20'h00002, 20'h000FF, 20'h00100,
            20'hAAAAA, 20'h55555, 20'h80000, 20'h7FFFF,
            20'd199979, 20'd199980, 20'd199981,   // x crossing 1.0
            20'd664320, 20'd399959, 20'd599938    // 2595 mel, x near 2.0, 3.0
        };
        send_mel(20'h00000, 1'b1);                // zero mel, with end mark
        foreach (corner[i])
            send_mel(corner[i], i[0]);
        send_mel(20'hFFFFF, 1'b0);
    endtask

    task automatic test_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_mel(20'($urandom_range(0, 20'hFFFFF)), ($urandom_range(0, 15) == 0));
    endtask

    // long output hold while input keeps coming, so the pipe backs up
    task automatic test_backpressure();
        hold_ticket++;
        test_random(80);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        mel_bus.valid     <= 1'b0;
        mel_bus.mel_value <= '0;
        mel_bus.is_last   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 66;
        test_corners();
        test_random(220);

        send_idle_pct = 66;
        recv_idle_pct = 11;
        test_random(220);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(160);
        mel_bus.valid <= 1'b0;

        while (hz_pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/mtoh_pkg.sv
rtl/core/mtoh_if.sv
rtl/core/mtoh_scale.sv
rtl/core/mtoh_exp2.sv
rtl/core/mtoh_hz.sv
rtl/core/mel_to_hz_converter_core.sv
tb/tb_top.sv
